[rtl/core/fsc_pkg.sv]
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared types and constants for the frustum sphere cull block.
// ----------------------------------------------------------------------------
package fsc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QUOT_BITS = 2 * FRAC_BITS + 1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_MLB  = 15'b000000000000010,
    S_MLO  = 15'b000000000000100,
    S_SQI  = 15'b000000000001000,
    S_SQA  = 15'b000000000010000,
    S_RTG  = 15'b000000000100000,
    S_RTW  = 15'b000000001000000,
    S_DVG  = 15'b000000010000000,
    S_DVW  = 15'b000000100000000,
    S_NMI  = 15'b000001000000000,
    S_NMW  = 15'b000010000000000,
    S_TI   = 15'b000100000000000,
    S_TA   = 15'b001000000000000,
    S_TC   = 15'b010000000000000,
    S_OUT  = 15'b100000000000000
  } state_t;

endpackage

[rtl/core/fsc_mul.sv]
// ----------------------------------------------------------------------------
// fsc_mul
// Registered fixed point multiply, truncated toward zero, saturated.
// ----------------------------------------------------------------------------
module fsc_mul #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic signed [VALUE_BITS-1:0] a,
  input  logic signed [VALUE_BITS-1:0] b,
  output logic signed [VALUE_BITS-1:0] prod
);
  import fsc_pkg::*;

  localparam int PW = 2 * VALUE_BITS;

  logic signed [PW-1:0] full;
  logic signed [PW-1:0] shifted;
  logic signed [PW-1:0] maxw;
  logic signed [PW-1:0] minw;

  assign maxw = {{(VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
  assign minw = ~maxw;
  assign full = a * b;

  always_comb begin
    if (full[PW-1]) begin
      shifted = (full + $signed(PW'((64'd1 << FRAC_BITS) - 64'd1))) >>> FRAC_BITS;
    end else begin
      shifted = full >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (shifted > maxw) begin
      prod <= maxw[VALUE_BITS-1:0];
    end else if (shifted < minw) begin
      prod <= minw[VALUE_BITS-1:0];
    end else begin
      prod <= shifted[VALUE_BITS-1:0];
    end
  end

endmodule

[rtl/core/fsc_sqrt.sv]
// ----------------------------------------------------------------------------
// fsc_sqrt
// Bit-serial integer square root of s * 2^16, one root bit per cycle.
// ----------------------------------------------------------------------------
module fsc_sqrt #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic [VALUE_BITS-1:0]                   s,
  output logic                                    busy,
  output logic [(VALUE_BITS+fsc_pkg::FRAC_BITS+1)/2-1:0] root
);
  import fsc_pkg::*;

  localparam int RW  = (VALUE_BITS + FRAC_BITS + 1) / 2;
  localparam int NW  = 2 * RW;
  localparam int MW  = RW + 3;
  localparam int CNW = $clog2(RW + 1);

  logic [NW-1:0]  nsh;
  logic [MW-1:0]  rem;
  logic [CNW-1:0] cnt;
  logic [MW-1:0]  rem_t;
  logic [MW-1:0]  trial;

  assign rem_t = {rem[MW-3:0], nsh[NW-1:NW-2]};
  assign trial = {{(MW-RW-2){1'b0}}, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNW'(RW);
      nsh  <= NW'({s, {FRAC_BITS{1'b0}}});
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      nsh <= {nsh[NW-3:0], 2'b00};
      if (rem_t >= trial) begin
        rem  <= rem_t - trial;
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem  <= rem_t;
        root <= {root[RW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CNW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/fsc_div.sv]
// ----------------------------------------------------------------------------
// fsc_div
// Restoring divider for 2^32 / len, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fsc_div #(
  parameter int LEN_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [LEN_BITS-1:0]            len,
  output logic                           busy,
  output logic [fsc_pkg::QUOT_BITS-1:0]  quot
);
  import fsc_pkg::*;

  localparam int CNW = $clog2(QUOT_BITS + 1);

  logic [LEN_BITS-1:0] dvs;
  logic [LEN_BITS:0]   rem;
  logic [CNW-1:0]      cnt;
  logic [LEN_BITS:0]   rem_t;
  logic                first;

  assign first = (cnt == CNW'(QUOT_BITS));
  assign rem_t = {rem[LEN_BITS-1:0], first};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNW'(QUOT_BITS);
      dvs  <= len;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      if (rem_t >= {1'b0, dvs}) begin
        rem  <= rem_t - {1'b0, dvs};
        quot <= {quot[QUOT_BITS-2:0], 1'b1};
      end else begin
        rem  <= rem_t;
        quot <= {quot[QUOT_BITS-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CNW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/frustum_sphere_cull.sv]
// ----------------------------------------------------------------------------
// frustum_sphere_cull
// Matrix load and sphere test against six extracted frustum planes.
//
//   channel  dir  handshake             payload
//   in       in   in_valid / in_ready   opcode, element_index, element_value,
//                                       center_x, center_y, center_z,
//                                       sphere_radius
//   out      out  out_valid / out_ready inside_res
//
// A load is written in the cycle it is accepted. A test runs through the
// shared multiplier (six planes, three multiply/accumulate pairs and one
// compare). After any load the first test rebuilds the planes first: per
// plane the combine, squared length, root, divide and normalise steps; a
// plane with a zero-length normal skips the divide and its start and wait
// states. In is ready only while idle; a test result waits in the output
// register. Reset is synchronous and clears the matrix and plane stores.
// ----------------------------------------------------------------------------
module frustum_sphere_cull #(
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [3:0]  element_index,
  input  logic signed [31:0] element_value,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic [30:0] sphere_radius,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        inside_res
);
  import fsc_pkg::*;

  localparam int V  = VALUE_BITS;
  localparam int RW = (V + FRAC_BITS + 1) / 2;
  localparam int IW = ((V > 32) ? V : 32) + 1;
  localparam int CW = ((QUOT_BITS > V) ? QUOT_BITS : V) + 1;

  function automatic logic signed [V-1:0] sat_in(input logic signed [IW-1:0] w);
    logic signed [IW-1:0] maxi;
    logic signed [IW-1:0] mini;
    maxi = {{(IW-V+1){1'b0}}, {(V-1){1'b1}}};
    mini = ~maxi;
    if (w > maxi) return maxi[V-1:0];
    if (w < mini) return mini[V-1:0];
    return w[V-1:0];
  endfunction

  function automatic logic signed [V-1:0] sat_add(input logic signed [V-1:0] a,
                                                 input logic signed [V-1:0] b);
    logic signed [V:0] s;
    s = {a[V-1], a} + {b[V-1], b};
    if (s[V] != s[V-1]) return s[V] ? {1'b1, {(V-1){1'b0}}} : {1'b0, {(V-1){1'b1}}};
    return s[V-1:0];
  endfunction

  state_t state;

  logic signed [V-1:0] matrix [0:15];
  logic signed [V-1:0] plane  [0:23];
  logic signed [V-1:0] cvec   [0:3];
  logic                stale;
  logic [2:0]          p;
  logic [1:0]          j;
  logic signed [V-1:0] base;
  logic signed [V-1:0] acc;
  logic signed [V-1:0] q;
  logic                norm;
  logic signed [V-1:0] x, y, z, r;
  logic                visible;

  logic signed [V-1:0] other;
  logic signed [V-1:0] pl_rd;
  logic signed [V-1:0] mul_a, mul_b, mres;
  logic                rt_start, rt_busy, dv_start, dv_busy;
  logic [RW-1:0]       root;
  logic [QUOT_BITS-1:0] quot;
  logic [CW-1:0]       quot_w, vmax_w;
  logic signed [V-1:0] dd;
  logic signed [V+1:0] chk;

  assign in_ready = (state == S_IDLE);
  assign other    = matrix[{j, p[2:1]}];
  assign pl_rd    = plane[(state == S_TC) ? 5'({p, 2'd3}) : 5'({p, j})];
  assign rt_start = (state == S_RTG);
  assign dv_start = (state == S_DVG);
  assign quot_w   = CW'(quot);
  assign vmax_w   = CW'({1'b0, {(V-1){1'b1}}});
  assign dd       = sat_add(acc, pl_rd);
  assign chk      = {{2{dd[V-1]}}, dd} + {{2{r[V-1]}}, r};

  always_comb begin
    mul_a = pl_rd;
    mul_b = x;
    priority if (state == S_SQI) begin
      mul_a = cvec[j];
      mul_b = cvec[j];
    end else if (state == S_NMI) begin
      mul_a = cvec[j];
      mul_b = q;
    end else if (j == 2'd1) begin
      mul_b = y;
    end else if (j == 2'd2) begin
      mul_b = z;
    end else begin
      mul_b = x;
    end
  end

  fsc_mul #(.VALUE_BITS(V)) u_mul (
    .clk(clk), .a(mul_a), .b(mul_b), .prod(mres)
  );

  fsc_sqrt #(.VALUE_BITS(V)) u_sqrt (
    .clk(clk), .rst(rst), .start(rt_start), .s(acc), .busy(rt_busy), .root(root)
  );

  fsc_div #(.LEN_BITS(RW)) u_div (
    .clk(clk), .rst(rst), .start(dv_start), .len(root), .busy(dv_busy), .quot(quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      stale     <= 1'b1;
      out_valid <= 1'b0;
      p         <= '0;
      j         <= '0;
      for (int i = 0; i < 16; i++) matrix[i] <= '0;
      for (int i = 0; i < 24; i++) plane[i] <= '0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (opcode == OP_LOAD) begin
              matrix[element_index] <= sat_in({{(IW-32){element_value[31]}}, element_value});
              stale <= 1'b1;
            end else begin
              x       <= sat_in({{(IW-32){center_x[31]}}, center_x});
              y       <= sat_in({{(IW-32){center_y[31]}}, center_y});
              z       <= sat_in({{(IW-32){center_z[31]}}, center_z});
              r       <= sat_in({{(IW-31){1'b0}}, sphere_radius});
              p       <= '0;
              j       <= '0;
              visible <= 1'b1;
              state   <= stale ? S_MLB : S_TI;
            end
          end
        end
        S_MLB: begin
          base  <= matrix[{j, 2'd3}];
          state <= S_MLO;
        end
        S_MLO: begin
          if (p[0]) begin
            cvec[j] <= sat_in(IW'(base) - IW'(other));
          end else begin
            cvec[j] <= sat_add(base, other);
          end
          if (j == 2'd3) begin
            j     <= '0;
            acc   <= '0;
            state <= S_SQI;
          end else begin
            j     <= j + 1'b1;
            state <= S_MLB;
          end
        end
        S_SQI: state <= S_SQA;
        S_SQA: begin
          acc <= sat_add(acc, mres);
          if (j == 2'd2) begin
            j     <= '0;
            state <= S_RTG;
          end else begin
            j     <= j + 1'b1;
            state <= S_SQI;
          end
        end
        S_RTG: state <= S_RTW;
        S_RTW: begin
          if (!rt_busy) begin
            norm  <= (root != '0);
            state <= (root != '0) ? S_DVG : S_NMI;
          end
        end
        S_DVG: state <= S_DVW;
        S_DVW: begin
          if (!dv_busy) begin
            q     <= (quot_w > vmax_w) ? vmax_w[V-1:0] : quot_w[V-1:0];
            state <= S_NMI;
          end
        end
        S_NMI: state <= S_NMW;
        S_NMW: begin
          plane[5'({p, j})] <= norm ? mres : cvec[j];
          if (j == 2'd3) begin
            j <= '0;
            if (p == 3'd5) begin
              p     <= '0;
              stale <= 1'b0;
              state <= S_TI;
            end else begin
              p     <= p + 1'b1;
              state <= S_MLB;
            end
          end else begin
            j     <= j + 1'b1;
            state <= S_NMI;
          end
        end
        S_TI: state <= S_TA;
        S_TA: begin
          acc <= (j == 2'd0) ? mres : sat_add(acc, mres);
          if (j == 2'd2) begin
            state <= S_TC;
          end else begin
            j     <= j + 1'b1;
            state <= S_TI;
          end
        end
        S_TC: begin
          if (chk[V+1]) visible <= 1'b0;
          j <= '0;
          if (p == 3'd5) begin
            p     <= '0;
            state <= S_OUT;
          end else begin
            p     <= p + 1'b1;
            state <= S_TI;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            inside_res <= visible;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
